### src/apq_pkg.sv
package apq_pkg;

	localparam int DEF_CAPACITY      = 16;
	localparam int DEF_VALUE_BITS    = 32;
	localparam int DEF_PRIORITY_BITS = 16;

	localparam int IN_VALUE_W  = 32;
	localparam int IN_PRIO_W   = 16;
	localparam int OUT_VALUE_W = 32;
	localparam int MODE_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int FILL_W      = 5;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POLL   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PEEK   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_SHIFT = 3'b100
	} state_t;

endpackage

### src/array_priority_queue.sv
// Priority queue of up to CAPACITY words held unsorted in one single-port-read,
// single-port-write synchronous memory. An insert, an operation with an unused
// mode code, and a poll or peek on an empty queue finish without a scan: done
// pulses in the cycle after start is taken and busy never rises. A peek on a
// queue of n entries reads every entry once through the one memory read port
// while busy stays high, and done follows. A poll does the same scan and then,
// when the winner at h is not the last entry, compacts the entries behind it,
// one read and one write per cycle. done is a single-cycle strobe that the
// receiver must take when it appears; nothing can stall it.
module array_priority_queue
	import apq_pkg::*;
#(
	parameter int CAPACITY      = DEF_CAPACITY,
	parameter int VALUE_BITS    = DEF_VALUE_BITS,
	parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [MODE_W-1:0]           mode,
	input  logic [IN_VALUE_W-1:0]       item_value,
	input  logic signed [IN_PRIO_W-1:0] item_priority,
	output logic                        done,
	output logic [OUT_VALUE_W-1:0]      out_value,
	output logic [STATUS_W-1:0]         status,
	output logic [FILL_W-1:0]           fill_count
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int W  = VALUE_BITS + PRIORITY_BITS;

	logic [W-1:0] mem [CAPACITY];
	logic [W-1:0] rd_data_s1;

	state_t state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] iss_q;
	logic          poll_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;

	logic [IW-1:0]                   best_idx_q;
	logic signed [PRIORITY_BITS-1:0] best_prio_q;
	logic [VALUE_BITS-1:0]           best_val_q;

	logic                   done_q;
	logic [OUT_VALUE_W-1:0] out_value_q;
	logic [STATUS_W-1:0]    status_q;
	logic [FILL_W-1:0]      fill_q;

	logic                            accept;
	logic                            rd_en;
	logic                            wr_en;
	logic [IW-1:0]                   wr_addr;
	logic [W-1:0]                    wr_data;
	logic signed [PRIORITY_BITS-1:0] ins_prio;
	logic [VALUE_BITS-1:0]           ins_val;
	logic signed [PRIORITY_BITS-1:0] rd_prio;
	logic [VALUE_BITS-1:0]           rd_val;
	logic                            take;
	logic [IW-1:0]                   head_idx;
	logic [VALUE_BITS-1:0]           head_val;
	logic [CW-1:0]                   cnt_m1;
	logic [IW-1:0]                   last_idx;
	logic                            at_last;

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign done       = done_q;
	assign out_value  = out_value_q;
	assign status     = status_q;
	assign fill_count = fill_q;

	assign ins_prio = PRIORITY_BITS'(item_priority);
	assign ins_val  = VALUE_BITS'(item_value);
	assign rd_prio  = rd_data_s1[W-1 -: PRIORITY_BITS];
	assign rd_val   = rd_data_s1[VALUE_BITS-1:0];
	assign cnt_m1   = cnt_q - CW'(1);
	assign last_idx = cnt_m1[IW-1:0];
	assign at_last  = vld_s1 && (idx_s1 == last_idx);

	// first entry seeds the search; later ones win only on a strictly larger priority
	assign take     = vld_s1 && ((idx_s1 == '0) || (rd_prio > best_prio_q));
	assign head_idx = take ? idx_s1 : best_idx_q;
	assign head_val = take ? rd_val : best_val_q;

	assign rd_en = (state_q != S_IDLE) && (iss_q < cnt_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1 - IW'(1);
		wr_data = rd_data_s1;
		if (state_q == S_IDLE) begin
			wr_en   = accept && (mode == MODE_INSERT) && (cnt_q < CW'(CAPACITY));
			wr_addr = cnt_q[IW-1:0];
			wr_data = {ins_prio, ins_val};
		end else if (state_q == S_SHIFT) begin
			wr_en = vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[iss_q[IW-1:0]];
		end
		idx_s1 <= iss_q[IW-1:0];
		if (take) begin
			best_idx_q  <= idx_s1;
			best_prio_q <= rd_prio;
			best_val_q  <= rd_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			iss_q       <= '0;
			poll_q      <= 1'b0;
			vld_s1      <= 1'b0;
			done_q      <= 1'b0;
			out_value_q <= '0;
			status_q    <= ST_OK;
			fill_q      <= '0;
		end else begin
			vld_s1 <= rd_en;
			done_q <= 1'b0;
			if (rd_en) begin
				iss_q <= iss_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						out_value_q <= '0;
						status_q    <= ST_OK;
						fill_q      <= FILL_W'(cnt_q);
						poll_q      <= (mode == MODE_POLL);
						iss_q       <= '0;
						if (mode == MODE_INSERT) begin
							done_q <= 1'b1;
							if (cnt_q < CW'(CAPACITY)) begin
								cnt_q  <= cnt_q + CW'(1);
								fill_q <= FILL_W'(cnt_q + CW'(1));
							end else begin
								status_q <= ST_FULL;
							end
						end else if (mode == MODE_POLL || mode == MODE_PEEK) begin
							if (cnt_q == '0) begin
								done_q   <= 1'b1;
								status_q <= ST_EMPTY;
							end else begin
								state_q <= S_SCAN;
							end
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_SCAN: begin
					if (at_last) begin
						out_value_q <= OUT_VALUE_W'(head_val);
						if (!poll_q) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (head_idx == last_idx) begin
							// winner is the tail: nothing to compact
							cnt_q   <= cnt_m1;
							fill_q  <= FILL_W'(cnt_m1);
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							iss_q   <= CW'(head_idx) + CW'(1);
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					if (at_last) begin
						cnt_q   <= cnt_m1;
						fill_q  <= FILL_W'(cnt_m1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_full_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ST_FULL) |-> (fill_q == FILL_W'(CAPACITY)))
		else $error("full status with queue not full");

	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ST_EMPTY) |-> (fill_q == '0 && out_value_q == '0))
		else $error("empty status with entries held");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && wr_en) |-> (CW'(wr_addr) + CW'(1) < cnt_q))
		else $error("compaction write outside held entries");

	a_shift_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && at_last) |=> (cnt_q == $past(cnt_q) - CW'(1) && done_q))
		else $error("poll did not remove one entry");
`endif

endmodule
